// ----- src/jmi_pkg.sv -----
// Shared constants, types and record layouts for the joint motion interpolator.
// Used by jmi_slot_table, jmi_div and joint_motion_interpolator; no dependencies.
package jmi_pkg;

	localparam int MAX_SLOTS   = 16;
	localparam int SERVO_COUNT = 12;
	localparam int TICK_BITS   = 16;

	localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W     = SLOT_W + 1;
	localparam int SERVO_W   = 4;
	localparam int SLOTNUM_W = 4;
	localparam int DUR_W     = 16;
	localparam int POS_W     = 16;
	localparam int GAIN_W    = 16;
	localparam int TICK_OUT_W = 16;
	localparam int END_W     = DUR_W + 1;
	localparam int CMP_W     = (TICK_BITS > END_W) ? TICK_BITS : END_W;
	localparam int LEN_W     = CMP_W + 1;

	localparam int DIV_W     = 16;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	localparam int PAD_TICKS = 100;
	localparam logic [TICK_BITS-1:0] TICK_MAX   = '1;
	localparam logic [TICK_BITS-1:0] PLEN_RESET = TICK_BITS'(PAD_TICKS);

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	typedef struct packed {
		logic [SERVO_W-1:0]      servo;
		logic [DUR_W-1:0]        start;
		logic [DUR_W-1:0]        length;
		logic signed [POS_W-1:0] target;
		logic [GAIN_W-1:0]       gain_p;
		logic [GAIN_W-1:0]       gain_d;
	} slot_rec_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		slot_rec_t         rec;
	} tbl_wr_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dvd;
		logic [DIV_W-1:0] dvs;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
	} div_rsp_t;

endpackage

// ----- src/jmi_slot_table.sv -----
// Motion slot storage: one write port, one registered read port, and per-slot
// valid flags cleared by reset. Depends on jmi_pkg.
module jmi_slot_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  jmi_pkg::tbl_wr_t            wr,
	input  logic [jmi_pkg::SLOT_W-1:0]  rd_addr,
	output jmi_pkg::slot_rec_t          rd_rec,
	output logic                        rd_valid
);

	jmi_pkg::slot_rec_t             mem [jmi_pkg::MAX_SLOTS];
	jmi_pkg::slot_rec_t             rd_rec_q;
	logic [jmi_pkg::MAX_SLOTS-1:0]  valid_q;
	logic                           rd_valid_q;

	// Record contents carry no reset; they are only trusted where the valid flag is set.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.rec;
		end
		rd_rec_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_rec   = rd_rec_q;
	assign rd_valid = rd_valid_q;

endmodule

// ----- src/jmi_div.sv -----
// Radix-2 restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Depends on jmi_pkg.
module jmi_div (
	input  logic              clk,
	input  logic              arst_n,
	input  jmi_pkg::div_req_t req,
	output jmi_pkg::div_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [jmi_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [jmi_pkg::DIV_W-1:0]     rem_q;
	logic [jmi_pkg::DIV_W-1:0]     quo_q;
	logic [jmi_pkg::DIV_W-1:0]     den_q;

	logic [jmi_pkg::DIV_W:0]       shifted;
	logic [jmi_pkg::DIV_W:0]       trial;
	logic                          fits;
	logic [jmi_pkg::DIV_W-1:0]     rem_nxt;

	// The dividend shifts out of the top of quo_q while quotient bits shift in below.
	assign shifted = {rem_q, quo_q[jmi_pkg::DIV_W-1]};
	assign trial   = shifted - {1'b0, den_q};
	assign fits    = (shifted >= {1'b0, den_q});
	assign rem_nxt = fits ? trial[jmi_pkg::DIV_W-1:0] : shifted[jmi_pkg::DIV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == jmi_pkg::DIV_CNT_W'(jmi_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dvd;
			den_q <= req.dvs;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[jmi_pkg::DIV_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ----- src/joint_motion_interpolator.sv -----
// Joint motion interpolator top level: sequencer, slot search and command datapath.
// A load transaction writes the slot, then sweeps every slot for the program length.
// A sample transaction searches the slots with one registered table read per cycle; on a hit
// it starts the divider and waits through its 16 serial divide steps and the done strobe, then
// enters the completion state, where a result not yet taken at the output holds it.
// Reset clears all slot valid flags, the tick counter to zero and program length to 100.
module joint_motion_interpolator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                func,
	input  logic [3:0]                          slot,
	input  logic [3:0]                          servo,
	input  logic [15:0]                         start_tick,
	input  logic [15:0]                         duration,
	input  logic signed [15:0]                  target_position,
	input  logic [15:0]                         gain_p_in,
	input  logic [15:0]                         gain_d_in,
	input  logic signed [15:0]                  measured_position,
	input  logic                                end_of_tick,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                active,
	output logic signed [15:0]                  commanded_position,
	output logic [15:0]                         gain_p_out,
	output logic [15:0]                         gain_d_out,
	output logic [3:0]                          motion_slot,
	output logic [15:0]                         tick,
	output logic                                finished
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LEN,
		S_SRCH,
		S_DIV_GO,
		S_DIV_WAIT,
		S_DONE
	} state_t;

	state_t                                state_q;
	logic [jmi_pkg::CNT_W-1:0]             cnt_q;
	logic                                  rd_tag_s1;
	logic                                  rd_last_s1;
	logic [jmi_pkg::SLOT_W-1:0]            rd_idx_s1;

	logic [jmi_pkg::SERVO_W-1:0]           servo_q;
	logic signed [jmi_pkg::POS_W-1:0]      meas_q;
	logic                                  eot_q;
	logic [jmi_pkg::TICK_BITS-1:0]         tick_q;
	logic [jmi_pkg::TICK_BITS-1:0]         plen_q;
	logic [jmi_pkg::END_W-1:0]             latest_q;
	logic                                  hit_q;
	logic [jmi_pkg::SLOT_W-1:0]            hit_idx_q;
	jmi_pkg::slot_rec_t                    hit_rec_q;
	logic                                  neg_q;
	logic [jmi_pkg::POS_W-1:0]             cmd_q;

	logic                                  out_valid_q;
	logic                                  active_q;
	logic [jmi_pkg::POS_W-1:0]             cmd_out_q;
	logic [jmi_pkg::GAIN_W-1:0]            gp_q;
	logic [jmi_pkg::GAIN_W-1:0]            gd_q;
	logic [jmi_pkg::SLOTNUM_W-1:0]         ms_q;
	logic [jmi_pkg::TICK_OUT_W-1:0]        tick_out_q;
	logic                                  fin_q;

	logic                                  in_acc;
	logic                                  load_ok;
	logic                                  issue;
	logic                                  out_free;
	jmi_pkg::tbl_wr_t                      tbl_wr;
	logic [jmi_pkg::SLOT_W-1:0]            rd_addr;
	jmi_pkg::slot_rec_t                    rd_rec;
	logic                                  rd_valid;

	logic [jmi_pkg::CMP_W-1:0]             now_c;
	logic [jmi_pkg::CMP_W-1:0]             s_c;
	logic [jmi_pkg::CMP_W-1:0]             e_c;
	logic                                  match;
	logic [jmi_pkg::END_W-1:0]             end_rd;
	logic [jmi_pkg::END_W-1:0]             latest_new;
	logic [jmi_pkg::LEN_W-1:0]             pad_len;
	logic [jmi_pkg::TICK_BITS-1:0]         plen_nxt;

	logic [jmi_pkg::CMP_W-1:0]             hit_end;
	logic [jmi_pkg::DIV_W-1:0]             left;
	logic signed [jmi_pkg::POS_W:0]        diff_w;
	logic [jmi_pkg::POS_W:0]               mag_w;
	jmi_pkg::div_req_t                     div_req;
	jmi_pkg::div_rsp_t                     div_rsp;
	logic [jmi_pkg::DIV_W-1:0]             step_w;
	logic [jmi_pkg::POS_W-1:0]             cmd_nxt;

	logic [jmi_pkg::TICK_BITS-1:0]         tick_nxt;
	logic                                  fin_nxt;

	// Input side is open whenever the sequencer is idle, even if a result is still
	// waiting to be taken at the output.
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Loads naming a slot or servo beyond the configured counts are dropped.
	assign load_ok = (func == jmi_pkg::FUNC_LOAD) &&
	                 (32'(slot) < jmi_pkg::MAX_SLOTS) &&
	                 (32'(servo) < jmi_pkg::SERVO_COUNT);

	// The table write happens on the accepting edge straight from the input ports.
	assign tbl_wr.en         = in_acc && load_ok;
	assign tbl_wr.addr       = jmi_pkg::SLOT_W'(slot);
	assign tbl_wr.rec.servo  = servo;
	assign tbl_wr.rec.start  = start_tick;
	assign tbl_wr.rec.length = duration;
	assign tbl_wr.rec.target = target_position;
	assign tbl_wr.rec.gain_p = gain_p_in;
	assign tbl_wr.rec.gain_d = gain_d_in;

	// One table read is issued per cycle during a sweep or a search. The length sweep
	// walks slots upward; the search walks downward so the first hit is the
	// highest-numbered covering slot.
	assign issue   = ((state_q == S_LEN) || (state_q == S_SRCH)) &&
	                 (cnt_q < jmi_pkg::CNT_W'(jmi_pkg::MAX_SLOTS));
	assign rd_addr = (state_q == S_SRCH) ?
	                 (jmi_pkg::SLOT_W'(jmi_pkg::MAX_SLOTS - 1) - cnt_q[jmi_pkg::SLOT_W-1:0]) :
	                 cnt_q[jmi_pkg::SLOT_W-1:0];

	jmi_slot_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (tbl_wr),
		.rd_addr  (rd_addr),
		.rd_rec   (rd_rec),
		.rd_valid (rd_valid)
	);

	// Coverage test of the record that came back from the table: start <= tick < end.
	assign now_c = jmi_pkg::CMP_W'(tick_q);
	assign s_c   = jmi_pkg::CMP_W'(rd_rec.start);
	assign e_c   = s_c + jmi_pkg::CMP_W'(rd_rec.length);
	assign match = rd_valid && (rd_rec.servo == servo_q) && (now_c >= s_c) && (now_c < e_c);

	// Running maximum of end ticks for the program length; the last record read is
	// folded in combinationally so the final compare sees it.
	assign end_rd     = jmi_pkg::END_W'(rd_rec.start) + jmi_pkg::END_W'(rd_rec.length);
	assign latest_new = (rd_valid && (end_rd > latest_q)) ? end_rd : latest_q;
	assign pad_len    = jmi_pkg::LEN_W'(latest_new) + jmi_pkg::LEN_W'(jmi_pkg::PAD_TICKS);
	assign plen_nxt   = (pad_len > jmi_pkg::LEN_W'(jmi_pkg::TICK_MAX)) ?
	                    jmi_pkg::TICK_MAX : jmi_pkg::TICK_BITS'(pad_len);

	// Divider operands: ticks left is at least one whenever a slot covers the tick,
	// and never exceeds the slot's duration. The difference is divided as a magnitude
	// and the sign is put back afterward, which truncates toward zero.
	assign hit_end = jmi_pkg::CMP_W'(hit_rec_q.start) + jmi_pkg::CMP_W'(hit_rec_q.length);
	assign left    = jmi_pkg::DIV_W'(hit_end - now_c);
	assign diff_w  = (jmi_pkg::POS_W + 1)'(hit_rec_q.target) - (jmi_pkg::POS_W + 1)'(meas_q);
	assign mag_w   = diff_w[jmi_pkg::POS_W] ? (jmi_pkg::POS_W + 1)'(-diff_w) :
	                 (jmi_pkg::POS_W + 1)'(diff_w);

	assign div_req.start = (state_q == S_DIV_GO);
	assign div_req.dvd   = jmi_pkg::DIV_W'(mag_w);
	assign div_req.dvs   = left;

	jmi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// The command is formed modulo 2^16, matching the truncation of the output field.
	assign step_w  = neg_q ? (~div_rsp.quo + jmi_pkg::DIV_W'(1)) : div_rsp.quo;
	assign cmd_nxt = jmi_pkg::POS_W'(meas_q) + jmi_pkg::POS_W'(step_w);

	// Tick advances after the sample when asked, saturating at the counter's top value.
	assign tick_nxt = (eot_q && (tick_q != jmi_pkg::TICK_MAX)) ? (tick_q + 1'b1) : tick_q;
	assign fin_nxt  = (tick_nxt >= plen_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rd_tag_s1   <= 1'b0;
			rd_last_s1  <= 1'b0;
			rd_idx_s1   <= '0;
			servo_q     <= '0;
			meas_q      <= '0;
			eot_q       <= 1'b0;
			tick_q      <= '0;
			plen_q      <= jmi_pkg::PLEN_RESET;
			latest_q    <= '0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			hit_rec_q   <= '0;
			neg_q       <= 1'b0;
			cmd_q       <= '0;
			out_valid_q <= 1'b0;
			active_q    <= 1'b0;
			cmd_out_q   <= '0;
			gp_q        <= '0;
			gd_q        <= '0;
			ms_q        <= '0;
			tick_out_q  <= '0;
			fin_q       <= 1'b0;
		end else begin
			rd_tag_s1  <= issue;
			rd_idx_s1  <= rd_addr;
			rd_last_s1 <= (cnt_q == jmi_pkg::CNT_W'(jmi_pkg::MAX_SLOTS - 1));
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			// The completion state publishes its own result, so the clear is left to it there.
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (func == jmi_pkg::FUNC_SAMPLE) begin
							servo_q <= servo;
							meas_q  <= measured_position;
							eot_q   <= end_of_tick;
							hit_q   <= 1'b0;
							cnt_q   <= '0;
							state_q <= S_SRCH;
						end else if (load_ok) begin
							cnt_q    <= '0;
							latest_q <= '0;
							state_q  <= S_LEN;
						end
					end
				end
				S_LEN: begin
					if (rd_tag_s1) begin
						latest_q <= latest_new;
						if (rd_last_s1) begin
							plen_q  <= plen_nxt;
							state_q <= S_IDLE;
						end
					end
				end
				S_SRCH: begin
					if (rd_tag_s1) begin
						if (match) begin
							hit_q     <= 1'b1;
							hit_idx_q <= rd_idx_s1;
							hit_rec_q <= rd_rec;
							state_q   <= S_DIV_GO;
						end else if (rd_last_s1) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DIV_GO: begin
					neg_q   <= diff_w[jmi_pkg::POS_W];
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_rsp.done) begin
						cmd_q   <= cmd_nxt;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// Hold here until the output register is free, then publish
					// the result and commit the tick advance together.
					if (out_free) begin
						out_valid_q <= 1'b1;
						active_q    <= hit_q;
						cmd_out_q   <= hit_q ? cmd_q : '0;
						gp_q        <= hit_q ? hit_rec_q.gain_p : '0;
						gd_q        <= hit_q ? hit_rec_q.gain_d : '0;
						ms_q        <= hit_q ? jmi_pkg::SLOTNUM_W'(hit_idx_q) : '0;
						tick_out_q  <= jmi_pkg::TICK_OUT_W'(tick_q);
						fin_q       <= fin_nxt;
						tick_q      <= tick_nxt;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign active             = active_q;
	assign commanded_position = cmd_out_q;
	assign gain_p_out         = gp_q;
	assign gain_d_out         = gd_q;
	assign motion_slot        = ms_q;
	assign tick               = tick_out_q;
	assign finished           = fin_q;

	// The divider only reports completion while the sequencer is waiting for it.
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV_WAIT))
		else $error("divider finished outside its wait state");

	// The tick counter moves only when a sample result is published.
	a_tick_moves_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_q != $past(tick_q)) |-> (($past(state_q) == S_DONE) && out_valid_q))
		else $error("tick counter changed outside result publication");

	// A new result appears only from the completion state.
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside completion state");

	// Program length never drops below the pad that reset sets.
	a_plen_floor: assert property (@(posedge clk) disable iff (!arst_n)
		plen_q >= jmi_pkg::PLEN_RESET)
		else $error("program length below its floor");

	// A search always ends once its last table read has been checked.
	a_search_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SRCH) && rd_tag_s1 && rd_last_s1) |=>
		((state_q == S_DIV_GO) || (state_q == S_DONE)))
		else $error("slot search overran the table");

endmodule
